// File: design/clf_pkg.sv
// shared types, constants and helpers for the cpuid leaf filter
package clf_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned XmaskW = 3;
  localparam int unsigned RegIdxW = 2;

  typedef enum logic [RegIdxW-1:0] {
    REG_MAX_LEAF     = 2'd0,
    REG_MAX_EXT_LEAF = 2'd1,
    REG_OSXSAVE      = 2'd2,
    REG_LONG_MODE    = 2'd3
  } clf_reg_e;

  // leaf numbers
  localparam logic [WordW-1:0] LeafMax      = 32'h0000_0000;
  localparam logic [WordW-1:0] LeafFeat     = 32'h0000_0001;
  localparam logic [WordW-1:0] LeafCache    = 32'h0000_0002;
  localparam logic [WordW-1:0] LeafTopo     = 32'h0000_0004;
  localparam logic [WordW-1:0] LeafExtFeat7 = 32'h0000_0007;
  localparam logic [WordW-1:0] LeafDca      = 32'h0000_0009;
  localparam logic [WordW-1:0] LeafXsave    = 32'h0000_000d;
  localparam logic [WordW-1:0] LeafTlb      = 32'h0000_0018;
  localparam logic [WordW-1:0] LeafHv       = 32'h4000_0000;
  localparam logic [WordW-1:0] LeafExtMax   = 32'h8000_0000;
  localparam logic [WordW-1:0] LeafExtFeat  = 32'h8000_0001;
  localparam logic [WordW-1:0] LeafBrand0   = 32'h8000_0002;
  localparam logic [WordW-1:0] LeafBrand1   = 32'h8000_0003;
  localparam logic [WordW-1:0] LeafBrand2   = 32'h8000_0004;
  localparam logic [WordW-1:0] LeafL2       = 32'h8000_0006;
  localparam logic [WordW-1:0] LeafAddr     = 32'h8000_0008;

  // caps and masks
  localparam logic [WordW-1:0] MaxLeafCap    = 32'h0000_0018;
  localparam logic [WordW-1:0] MaxExtLeafCap = 32'h8000_0008;
  localparam logic [WordW-1:0] Feat1CMask    = 32'h76de_3217;
  localparam logic [WordW-1:0] HvPresentBit  = 32'h8000_0000;
  localparam logic [WordW-1:0] Feat1DMask    = 32'h0f8a_a579;
  localparam logic [WordW-1:0] XsaveBits     = 32'h1c00_0000;
  localparam int unsigned      OsxsaveBit    = 27;
  localparam logic [WordW-1:0] Feat7BMask    = 32'h0000_2369;
  localparam logic [WordW-1:0] Feat7BNoXs    = 32'hdc23_0020;
  localparam logic [WordW-1:0] ExtCMask      = 32'h0000_0121;
  localparam logic [WordW-1:0] ExtDMaskLong  = 32'h2410_0800;
  localparam logic [WordW-1:0] ExtDMaskLeg   = 32'h0410_0000;

  // hypervisor signature
  localparam logic [WordW-1:0] HvSigB = 32'h4b4d_564b;
  localparam logic [WordW-1:0] HvSigC = 32'h564b_4d56;
  localparam logic [WordW-1:0] HvSigD = 32'h0000_004d;

  // xsave area sizes
  localparam logic [WordW-1:0] XsizeSse = 32'd576;
  localparam logic [WordW-1:0] XsizeAvx = 32'd832;
  localparam logic [WordW-1:0] XsizeYmm = XsizeAvx - XsizeSse;

  typedef struct packed {
    logic [WordW-1:0]  leaf;
    logic [WordW-1:0]  subleaf;
    logic [WordW-1:0]  host_a;
    logic [WordW-1:0]  host_b;
    logic [WordW-1:0]  host_c;
    logic [WordW-1:0]  host_d;
    logic              guest_osxsave;
    logic [XmaskW-1:0] xstate_mask;
  } clf_in_t;

  typedef struct packed {
    logic [WordW-1:0] out_a;
    logic [WordW-1:0] out_b;
    logic [WordW-1:0] out_c;
    logic [WordW-1:0] out_d;
  } clf_out_t;

  typedef struct packed {
    logic [WordW-1:0] max_leaf;
    logic [WordW-1:0] max_ext_leaf;
    logic             osxsave;
    logic             long_mode;
  } clf_cfg_t;

  function automatic logic [WordW-1:0] xsave_size(input logic [XmaskW-1:0] m);
    logic [WordW-1:0] s;
    unique case (m)
      3'd1, 3'd3: s = XsizeSse;
      3'd7:       s = XsizeAvx;
      default:    s = '0;
    endcase
    return s;
  endfunction

endpackage

// File: design/cpuid_leaf_filter.sv
// top level of the cpuid leaf filter: input register, filter logic, result register
// path: an accepted item is held in the input register, filtered, then held in the result register before it is offered
// throughput: one item per cycle; the block keeps taking items while a result waits,
//   stalling only when both registers hold items and out_ready_i is low
// reset: both valid flags clear; config registers return to max leaf 0, max extended
//   leaf 0x80000000, host osxsave off and long mode on
module cpuid_leaf_filter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  clf_pkg::clf_in_t                in_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output clf_pkg::clf_out_t               out_o,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [clf_pkg::RegIdxW-1:0]     cfg_idx_i,
  input  logic [clf_pkg::WordW-1:0]       cfg_wdata_i
);
  import clf_pkg::*;

  // configuration registers
  clf_cfg_t cfg_q, cfg_d;

  // input stage
  logic    in_vld_q, in_vld_d;
  clf_in_t in_q, in_d;

  // result stage
  logic     out_vld_q, out_vld_d;
  clf_out_t out_q, out_d;
  clf_out_t rsp;

  logic in_adv;
  logic out_adv;

  // register writes, unknown indexes cannot occur with a two-bit index
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (clf_reg_e'(cfg_idx_i))
        REG_MAX_LEAF:     cfg_d.max_leaf     = cfg_wdata_i;
        REG_MAX_EXT_LEAF: cfg_d.max_ext_leaf = cfg_wdata_i;
        REG_OSXSAVE:      cfg_d.osxsave      = cfg_wdata_i[0];
        REG_LONG_MODE:    cfg_d.long_mode    = cfg_wdata_i[0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_leaf     <= '0;
      cfg_q.max_ext_leaf <= MaxExtLeafCap & ~32'h0000_000f;
      cfg_q.osxsave      <= 1'b0;
      cfg_q.long_mode    <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ready chains back: a stage may load when empty or when it empties this cycle
  assign out_adv    = !out_vld_q || out_ready_i;
  assign in_adv     = !in_vld_q || out_adv;
  assign in_ready_o = in_adv;

  always_comb begin
    in_vld_d = in_vld_q;
    in_d     = in_q;
    if (in_adv) begin
      in_vld_d = in_valid_i;
      in_d     = in_i;
    end
  end

  // filter sits between the two registers
  clf_filter u_filter (
    .req_i (in_q),
    .cfg_i (cfg_q),
    .rsp_o (rsp)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (out_adv) begin
      out_vld_d = in_vld_q;
      out_d     = rsp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  // a result only appears from a full input stage or a held result
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_vld_q))
    else $error("result valid without an item in the input stage");

  // both stages full and output stalled must block new items
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && !out_ready_i) |-> !in_ready_o)
    else $error("item taken while pipeline full");

  // a blocked input stage keeps its item
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !out_adv) |=> (in_vld_q && $stable(in_q)))
    else $error("input stage item lost during stall");

endmodule

// File: design/clf_filter.sv
// leaf decode and masking of one cpuid request
module clf_filter (
  input  clf_pkg::clf_in_t  req_i,
  input  clf_pkg::clf_cfg_t cfg_i,
  output clf_pkg::clf_out_t rsp_o
);
  import clf_pkg::*;

  logic [WordW-1:0] c1;

  always_comb begin
    c1 = (req_i.host_c & Feat1CMask) | HvPresentBit;
    if (cfg_i.osxsave) begin
      if (req_i.guest_osxsave) c1[OsxsaveBit] = 1'b1;
    end else begin
      c1 = c1 & ~XsaveBits;
    end
  end

  always_comb begin
    rsp_o = '0;
    unique case (req_i.leaf)
      LeafMax: begin
        rsp_o.out_a = (cfg_i.max_leaf < MaxLeafCap) ? cfg_i.max_leaf : MaxLeafCap;
        rsp_o.out_b = req_i.host_b;
        rsp_o.out_c = req_i.host_c;
        rsp_o.out_d = req_i.host_d;
      end
      LeafFeat: begin
        rsp_o.out_a = req_i.host_a;
        rsp_o.out_b = {16'h0, req_i.host_b[15:0]};
        rsp_o.out_c = c1;
        rsp_o.out_d = req_i.host_d & Feat1DMask;
      end
      LeafExtFeat7: begin
        if (req_i.subleaf == '0) begin
          rsp_o.out_b = cfg_i.osxsave ? (req_i.host_b & Feat7BMask)
                                      : (req_i.host_b & Feat7BMask & ~Feat7BNoXs);
        end
      end
      LeafXsave: begin
        if (cfg_i.osxsave) begin
          if (req_i.subleaf == 32'd0) begin
            rsp_o.out_a = {{(WordW-XmaskW){1'b0}}, req_i.host_a[XmaskW-1:0]};
            rsp_o.out_b = xsave_size(req_i.xstate_mask);
            rsp_o.out_c = xsave_size(req_i.host_a[XmaskW-1:0]);
          end else if (req_i.subleaf == 32'd1) begin
            rsp_o.out_a = {{(WordW-XmaskW){1'b0}}, req_i.host_a[XmaskW-1:0]};
            rsp_o.out_b = xsave_size(req_i.xstate_mask);
          end else if (req_i.subleaf == 32'd2) begin
            rsp_o.out_a = XsizeYmm;
            rsp_o.out_b = XsizeSse;
          end
        end
      end
      LeafHv: begin
        rsp_o.out_b = HvSigB;
        rsp_o.out_c = HvSigC;
        rsp_o.out_d = HvSigD;
      end
      LeafExtMax: begin
        rsp_o.out_a = (cfg_i.max_ext_leaf < MaxExtLeafCap) ? cfg_i.max_ext_leaf
                                                           : MaxExtLeafCap;
      end
      LeafExtFeat: begin
        rsp_o.out_a = req_i.host_a;
        rsp_o.out_c = req_i.host_c & ExtCMask;
        rsp_o.out_d = req_i.host_d & (cfg_i.long_mode ? ExtDMaskLong : ExtDMaskLeg);
      end
      LeafCache, LeafTopo, LeafDca, LeafTlb,
      LeafBrand0, LeafBrand1, LeafBrand2, LeafL2, LeafAddr: begin
        rsp_o.out_a = req_i.host_a;
        rsp_o.out_b = req_i.host_b;
        rsp_o.out_c = req_i.host_c;
        rsp_o.out_d = req_i.host_d;
      end
      default: rsp_o = '0;
    endcase
  end

endmodule
